@@ hdl/nlj_pkg.sv @@
// ============================================================================
// nlj_pkg
// Shared types and constants of the nested-loop join engine: table sizing,
// function and mode codes, register selects, configuration and result types.
// ============================================================================
package nlj_pkg;

   // table and index sizing
   localparam int TABLE_DEPTH       = 64;
   localparam int ADDR_BITS         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_BITS        = $clog2(TABLE_DEPTH + 1);
   localparam int PROBE_INDEX_BITS  = 16;

   // fixed field widths
   localparam int KEY_BITS          = 64;
   localparam int PROBE_FIELD_BITS  = 16;
   localparam int STORED_FIELD_BITS = 6;
   localparam int REQ_TDATA_BITS    = 64;
   localparam int REQ_TUSER_BITS    = 2;
   localparam int RSP_TDATA_BITS    = 24;
   localparam int RSP_TUSER_BITS    = 2;
   localparam int CSR_ADDR_BITS     = 4;
   localparam int CSR_DATA_BITS     = 64;

   // response tdata bit positions
   localparam int RSP_PIDX_LSB      = 0;
   localparam int RSP_SIDX_LSB      = RSP_PIDX_LSB + PROBE_FIELD_BITS;
   localparam int RSP_OVF_BIT       = RSP_SIDX_LSB + STORED_FIELD_BITS;
   // response tuser bit positions
   localparam int RSP_PNULL_BIT     = 0;
   localparam int RSP_SNULL_BIT     = 1;

   // request function codes
   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_PROBE = 2'd1,
      FUNC_FLUSH = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   // join modes
   typedef enum logic [1:0] {
      MODE_INNER = 2'd0,
      MODE_LEFT  = 2'd1,
      MODE_FULL  = 2'd2,
      MODE_CROSS = 2'd3
   } mode_type;

   // register select, taken from address bit 3
   typedef enum logic {
      REG_JOIN_MODE = 1'b0,
      REG_KEY_MASK  = 1'b1
   } reg_sel_type;

   // scan sequencer states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_FINAL = 2'd2
   } state_type;

   // configuration seen by the engine
   typedef struct packed {
      mode_type              join_mode;
      logic [KEY_BITS-1:0]   key_mask;
   } cfg_type;

   // one result row on its way to the output register
   typedef struct packed {
      logic [PROBE_FIELD_BITS-1:0]  probe_index;
      logic [STORED_FIELD_BITS-1:0] stored_index;
      logic                         probe_is_null;
      logic                         stored_is_null;
      logic                         last;
   } rsp_item_type;

endpackage

@@ hdl/nlj_ram.sv @@
// ============================================================================
// nlj_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read that updates only when a read is enabled.
// ============================================================================
module nlj_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/nlj_csr.sv @@
// ============================================================================
// nlj_csr
// APB-style register block holding the join mode and the key mask.
// ============================================================================
module nlj_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nlj_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [nlj_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [nlj_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output nlj_pkg::cfg_type                   cfg
);

   nlj_pkg::mode_type                 mode_ff, mode_in;
   logic [nlj_pkg::KEY_BITS-1:0]      mask_ff, mask_in;
   nlj_pkg::reg_sel_type              sel;
   logic                              wr_en;

   assign sel   = nlj_pkg::reg_sel_type'(csr_paddr[3]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // write decode
   always_comb begin
      mode_in = mode_ff;
      mask_in = mask_ff;
      if (wr_en) begin
         unique case (sel)
            nlj_pkg::REG_JOIN_MODE: mode_in = nlj_pkg::mode_type'(csr_pwdata[1:0]);
            nlj_pkg::REG_KEY_MASK:  mask_in = csr_pwdata[nlj_pkg::KEY_BITS-1:0];
            default:                mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= nlj_pkg::MODE_INNER;
         mask_ff <= '1;
      end else begin
         mode_ff <= mode_in;
         mask_ff <= mask_in;
      end
   end

   // read mux
   always_comb begin
      unique case (sel)
         nlj_pkg::REG_JOIN_MODE: csr_prdata = nlj_pkg::CSR_DATA_BITS'(mode_ff);
         nlj_pkg::REG_KEY_MASK:  csr_prdata = nlj_pkg::CSR_DATA_BITS'(mask_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign csr_pready     = 1'b1;
   assign cfg.join_mode  = mode_ff;
   assign cfg.key_mask   = mask_ff;

endmodule

@@ hdl/nested_loop_join_engine.sv @@
// ============================================================================
// nested_loop_join_engine
// Nested-loop join over a table of stored keys with inner, left, full outer
// and cross modes; results carry row indices.
// ============================================================================
// Usage
//   req channel: one transaction per load, probe, flush or clear; tuser holds
//   the function code, tdata the 64-bit key. rsp channel: result rows, tlast
//   marks the final row caused by one request. csr port: join_mode at 0x0,
//   key_mask at 0x8; the user must write them only while idle: not enforced.
// Timing
//   A load or clear leaves the engine idle, so they stream at one per cycle. A
//   probe or flush scans the key and mark RAMs one entry per cycle while the
//   output is not stalled; no new transaction is taken until the scan ends.
//   A matching row is read from the RAMs, registered, and held until the next
//   match or the scan end decides its tlast, then enters the output register.
// Reset
//   Clears the table count, the probe counter and the overflow flag. Neither
//   RAM is cleared: only loaded entries are read, and each load resets the
//   matched mark of the entry it fills.
// Backpressure
//   While rsp_tready is low with a row waiting, the scan freezes in place,
//   RAM read data included, and resumes without loss.
// ============================================================================
module nested_loop_join_engine (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = key_value[63:0]; tuser = func[1:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [nlj_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   input  logic [nlj_pkg::REQ_TUSER_BITS-1:0]  req_tuser,
   // response: tdata = probe_index[15:0], stored_index[21:16], overflow[22],
   //           zero[23]; tuser = probe_is_null[0], stored_is_null[1]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [nlj_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   output logic [nlj_pkg::RSP_TUSER_BITS-1:0]  rsp_tuser,
   output logic                                rsp_tlast,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nlj_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [nlj_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [nlj_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   localparam int AW = nlj_pkg::ADDR_BITS;
   localparam int CW = nlj_pkg::COUNT_BITS;

   nlj_pkg::cfg_type                        cfg;
   nlj_pkg::state_type                      state_ff, state_in;

   logic [CW-1:0]                           count_ff, count_in;
   logic [nlj_pkg::PROBE_INDEX_BITS-1:0]    probe_cnt_ff, probe_cnt_in;
   logic                                    ovf_ff, ovf_in;

   logic [nlj_pkg::KEY_BITS-1:0]            key_ff, key_in;
   logic                                    is_probe_ff, is_probe_in;
   logic [CW-1:0]                           rd_idx_ff, rd_idx_in;
   logic                                    dv_ff, dv_in;
   logic [AW-1:0]                           didx_ff, didx_in;
   logic                                    any_ff, any_in;

   logic                                    hold_v_ff, hold_v_in;
   logic [AW-1:0]                           hold_idx_ff, hold_idx_in;
   logic                                    hold_pnull_ff, hold_pnull_in;

   logic                                    out_v_ff, out_v_in;
   nlj_pkg::rsp_item_type                   out_ff, out_in;
   logic                                    out_ovf_ff, out_ovf_in;

   logic                                    accept;
   nlj_pkg::func_type                       func;
   logic                                    adv;
   logic                                    scan_done;
   logic                                    hit;
   logic                                    push;
   nlj_pkg::rsp_item_type                   push_item;
   logic                                    outer_mode;

   logic                                    ram_we;
   logic [AW-1:0]                           ram_waddr;
   logic                                    ram_re;
   logic [AW-1:0]                           ram_raddr;
   logic [nlj_pkg::KEY_BITS-1:0]            ram_rdata;

   logic                                    mark_we;
   logic [AW-1:0]                           mark_waddr;
   logic                                    mark_wdata;
   logic                                    mark_rdata;

   // configuration registers
   nlj_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // stored key table; writes happen only while idle, reads only while
   // scanning, so the two ports never touch one entry in the same cycle
   nlj_ram #(
      .WIDTH (nlj_pkg::KEY_BITS),
      .DEPTH (nlj_pkg::TABLE_DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_tdata[nlj_pkg::KEY_BITS-1:0]),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // matched marks, read beside the keys; a load clears the mark it fills and
   // a full-mode probe sets the mark one entry behind the read pointer
   nlj_ram #(
      .WIDTH (1),
      .DEPTH (nlj_pkg::TABLE_DEPTH)
   ) u_mark_ram (
      .clock (clock),
      .we    (mark_we),
      .waddr (mark_waddr),
      .wdata (mark_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (mark_rdata)
   );

   assign func       = nlj_pkg::func_type'(req_tuser[1:0]);
   assign accept     = req_tvalid & req_tready;
   assign adv        = ~out_v_ff | rsp_tready;
   assign scan_done  = ~dv_ff & (rd_idx_ff == count_ff);
   assign outer_mode = (cfg.join_mode == nlj_pkg::MODE_LEFT) ||
                       (cfg.join_mode == nlj_pkg::MODE_FULL);
   assign ram_raddr  = rd_idx_ff[AW-1:0];
   assign ram_waddr  = count_ff[AW-1:0];

   // match test on the registered RAM read data; a flush hits unmatched full-mode entries
   always_comb begin
      if (is_probe_ff) begin
         hit = (cfg.join_mode == nlj_pkg::MODE_CROSS) ||
               (((key_ff ^ ram_rdata) & cfg.key_mask) == '0);
      end else begin
         hit = (cfg.join_mode == nlj_pkg::MODE_FULL) && !mark_rdata;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nlj_pkg::ST_IDLE: begin
            if (accept && (func == nlj_pkg::FUNC_PROBE || func == nlj_pkg::FUNC_FLUSH)) begin
               state_in = nlj_pkg::ST_SCAN;
            end
         end
         nlj_pkg::ST_SCAN: begin
            if (adv && scan_done) begin
               state_in = nlj_pkg::ST_FINAL;
            end
         end
         nlj_pkg::ST_FINAL: begin
            if (adv) begin
               state_in = nlj_pkg::ST_IDLE;
            end
         end
         default: state_in = nlj_pkg::ST_IDLE;
      endcase
   end

   // datapath and sequencer outputs
   always_comb begin
      count_in      = count_ff;
      probe_cnt_in  = probe_cnt_ff;
      ovf_in        = ovf_ff;
      key_in        = key_ff;
      is_probe_in   = is_probe_ff;
      rd_idx_in     = rd_idx_ff;
      dv_in         = dv_ff;
      didx_in       = didx_ff;
      any_in        = any_ff;
      hold_v_in     = hold_v_ff;
      hold_idx_in   = hold_idx_ff;
      hold_pnull_in = hold_pnull_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      mark_we       = 1'b0;
      mark_waddr    = ram_waddr;
      mark_wdata    = 1'b0;
      push          = 1'b0;
      req_tready    = 1'b0;
      // the held row, with probe index suppressed on the null probe side
      push_item.probe_index    = hold_pnull_ff ? '0 :
                                 nlj_pkg::PROBE_FIELD_BITS'(probe_cnt_ff);
      push_item.stored_index   = nlj_pkg::STORED_FIELD_BITS'(hold_idx_ff);
      push_item.probe_is_null  = hold_pnull_ff;
      push_item.stored_is_null = 1'b0;
      push_item.last           = 1'b0;

      unique case (state_ff)
         nlj_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               case (func)
                  nlj_pkg::FUNC_LOAD: begin
                     if (count_ff < CW'(nlj_pkg::TABLE_DEPTH)) begin
                        ram_we   = 1'b1;
                        mark_we  = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  nlj_pkg::FUNC_CLEAR: begin
                     count_in     = '0;
                     probe_cnt_in = '0;
                     ovf_in       = 1'b0;
                  end
                  default: begin
                     key_in      = req_tdata[nlj_pkg::KEY_BITS-1:0];
                     is_probe_in = (func == nlj_pkg::FUNC_PROBE);
                     rd_idx_in   = '0;
                     dv_in       = 1'b0;
                     any_in      = 1'b0;
                     hold_v_in   = 1'b0;
                  end
               endcase
            end
         end
         nlj_pkg::ST_SCAN: begin
            if (adv) begin
               // consume the entry held in the RAM read register
               if (dv_ff && hit) begin
                  any_in = 1'b1;
                  if (is_probe_ff && cfg.join_mode == nlj_pkg::MODE_FULL) begin
                     mark_we    = 1'b1;
                     mark_waddr = didx_ff;
                     mark_wdata = 1'b1;
                  end
                  push          = hold_v_ff;
                  hold_v_in     = 1'b1;
                  hold_idx_in   = didx_ff;
                  hold_pnull_in = ~is_probe_ff;
               end
               // issue the next read
               if (rd_idx_ff < count_ff) begin
                  ram_re    = 1'b1;
                  rd_idx_in = rd_idx_ff + CW'(1);
                  dv_in     = 1'b1;
                  didx_in   = ram_raddr;
               end else begin
                  dv_in = 1'b0;
               end
            end
         end
         nlj_pkg::ST_FINAL: begin
            if (adv) begin
               if (hold_v_ff) begin
                  push           = 1'b1;
                  push_item.last = 1'b1;
                  hold_v_in      = 1'b0;
               end else if (is_probe_ff && !any_ff && outer_mode) begin
                  // unmatched probe row with a null stored side
                  push                     = 1'b1;
                  push_item.probe_index    = nlj_pkg::PROBE_FIELD_BITS'(probe_cnt_ff);
                  push_item.stored_index   = '0;
                  push_item.probe_is_null  = 1'b0;
                  push_item.stored_is_null = 1'b1;
                  push_item.last           = 1'b1;
               end
               if (is_probe_ff) begin
                  probe_cnt_in = probe_cnt_ff + nlj_pkg::PROBE_INDEX_BITS'(1);
               end
            end
         end
         default: req_tready = 1'b0;
      endcase
   end

   // output register
   always_comb begin
      out_v_in   = out_v_ff;
      out_in     = out_ff;
      out_ovf_in = out_ovf_ff;
      if (push) begin
         out_v_in   = 1'b1;
         out_in     = push_item;
         out_ovf_in = ovf_ff;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nlj_pkg::ST_IDLE;
         count_ff     <= '0;
         probe_cnt_ff <= '0;
         ovf_ff       <= 1'b0;
         dv_ff        <= 1'b0;
         hold_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         probe_cnt_ff <= probe_cnt_in;
         ovf_ff       <= ovf_in;
         dv_ff        <= dv_in;
         hold_v_ff    <= hold_v_in;
         out_v_ff     <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      is_probe_ff   <= is_probe_in;
      rd_idx_ff     <= rd_idx_in;
      didx_ff       <= didx_in;
      any_ff        <= any_in;
      hold_idx_ff   <= hold_idx_in;
      hold_pnull_ff <= hold_pnull_in;
      out_ff        <= out_in;
      out_ovf_ff    <= out_ovf_in;
   end

   // response packing
   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {1'b0, out_ovf_ff, out_ff.stored_index, out_ff.probe_index};
   assign rsp_tuser  = {out_ff.stored_is_null, out_ff.probe_is_null};

endmodule

@@ hdl/nlj_checker.sv @@
// ============================================================================
// nlj_checker
// Port-level checks on the join engine's response channel, bound to the
// top level.
// ============================================================================
module nlj_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [nlj_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   input logic [nlj_pkg::RSP_TUSER_BITS-1:0]  rsp_tuser,
   input logic                                rsp_tlast
);

   // a stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // no row pads both sides
   a_one_null: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[nlj_pkg::RSP_PNULL_BIT] &&
                       rsp_tuser[nlj_pkg::RSP_SNULL_BIT]))
      else $error("row with both sides null");

   // null stored row has index zero and closes its probe
   a_snull_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[nlj_pkg::RSP_SNULL_BIT] |->
         rsp_tlast && (rsp_tdata[nlj_pkg::RSP_OVF_BIT-1:nlj_pkg::RSP_SIDX_LSB] == '0))
      else $error("bad null stored row");

   // null probe row has probe index zero
   a_pnull_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[nlj_pkg::RSP_PNULL_BIT] |->
         (rsp_tdata[nlj_pkg::RSP_SIDX_LSB-1:nlj_pkg::RSP_PIDX_LSB] == '0))
      else $error("bad null probe row");

   // reset empties the output register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind nested_loop_join_engine nlj_checker u_nlj_checker (.*);

@@ dv/tb_nested_loop_join_engine.sv @@
// ============================================================================
// tb_nested_loop_join_engine
// Self-checking testbench for the nested-loop join engine. Requests go in on
// the req stream, result rows come back on the rsp stream, and the join mode
// and key mask are set over the csr port while the engine is idle. A
// behavioral model of the stored table, matched marks, probe counter and
// overflow flag predicts every row, and each received row is compared field
// by field with the oldest predicted one. Named tests cover directed cases,
// table overflow, output backpressure and random joins.
// ============================================================================
module tb_nested_loop_join_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 80;
   localparam int END_CYCLES      = 100;
   localparam int IDLE_LIMIT      = 2000;
   localparam int RANDOM_ITEMS    = 205;
   localparam int MAX_PRINTED     = 30;

   // one predicted result row
   typedef struct packed {
      logic [15:0] probe_index;
      logic [5:0]  stored_index;
      logic        probe_is_null;
      logic        stored_is_null;
      logic        overflow;
      logic        last;
   } join_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [nlj_pkg::REQ_TDATA_BITS-1:0] req_tdata  = '0;   // key_value[63:0]
   logic [nlj_pkg::REQ_TUSER_BITS-1:0] req_tuser  = '0;   // func[1:0]
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   // probe_index, stored_index, overflow, zero
   logic [nlj_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [nlj_pkg::RSP_TUSER_BITS-1:0] rsp_tuser;         // probe_is_null, stored_is_null
   logic                               rsp_tlast;
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [nlj_pkg::CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [nlj_pkg::CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [nlj_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                               csr_pready;

   // join model state
   logic [nlj_pkg::KEY_BITS-1:0] table_keys [nlj_pkg::TABLE_DEPTH];
   bit                           table_matched [nlj_pkg::TABLE_DEPTH];
   int unsigned                  table_count    = 0;
   logic [15:0]                  probe_counter  = '0;
   bit                           overflow_seen  = 1'b0;
   nlj_pkg::mode_type            active_mode    = nlj_pkg::MODE_INNER;
   logic [nlj_pkg::KEY_BITS-1:0] active_mask    = '1;

   join_row_type expected_join_rows [$];

   int unsigned error_count     = 0;
   int unsigned rows_received   = 0;
   int unsigned requests_sent   = 0;
   int unsigned idle_cycles     = 0;
   int unsigned hold_off_left   = 0;
   bit          hold_off_request = 1'b0;
   bit          steady_flow      = 1'b0;

   nested_loop_join_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic logic [63:0] random_key();
      return {$urandom, $urandom};
   endfunction

   function automatic join_row_type make_row(logic [15:0] pidx, int unsigned sidx,
                                             logic pnull, logic snull);
      join_row_type row;
      row.probe_index    = pidx;
      row.stored_index   = sidx[5:0];
      row.probe_is_null  = pnull;
      row.stored_is_null = snull;
      row.overflow       = overflow_seen;
      row.last           = 1'b0;
      return row;
   endfunction

   // update the join model for one accepted request and queue its rows
   task automatic join_predict(input nlj_pkg::func_type func, input logic [63:0] key);
      join_row_type rows [$];
      bit any_hit;
      bit hit;
      case (func)
         nlj_pkg::FUNC_LOAD: begin
            if (table_count < nlj_pkg::TABLE_DEPTH) begin
               table_keys[table_count]    = key;
               table_matched[table_count] = 1'b0;
               table_count++;
            end else begin
               overflow_seen = 1'b1;
            end
         end
         nlj_pkg::FUNC_CLEAR: begin
            foreach (table_matched[i]) table_matched[i] = 1'b0;
            table_count   = 0;
            probe_counter = '0;
            overflow_seen = 1'b0;
         end
         nlj_pkg::FUNC_PROBE: begin
            any_hit = 1'b0;
            for (int i = 0; i < table_count; i++) begin
               hit = (active_mode == nlj_pkg::MODE_CROSS) ||
                     (((key ^ table_keys[i]) & active_mask) == '0);
               if (hit) begin
                  any_hit = 1'b1;
                  if (active_mode == nlj_pkg::MODE_FULL) table_matched[i] = 1'b1;
                  rows.push_back(make_row(probe_counter, i, 1'b0, 1'b0));
               end
            end
            // unmatched probe keeps a row with a null stored side
            if (!any_hit && (active_mode == nlj_pkg::MODE_LEFT ||
                             active_mode == nlj_pkg::MODE_FULL))
               rows.push_back(make_row(probe_counter, 0, 1'b0, 1'b1));
            probe_counter++;
         end
         nlj_pkg::FUNC_FLUSH: begin
            if (active_mode == nlj_pkg::MODE_FULL) begin
               for (int i = 0; i < table_count; i++) begin
                  if (!table_matched[i]) rows.push_back(make_row(16'd0, i, 1'b1, 1'b0));
               end
            end
         end
      endcase
      if (rows.size() > 0) rows[rows.size()-1].last = 1'b1;
      foreach (rows[i]) expected_join_rows.push_back(rows[i]);
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("ERROR %0t ns: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("row %0d %s: got %0d, expected %0d",
                                   rows_received, name, got, want));
   endtask

   // compare one received row with the oldest expected row
   task automatic check_join_row();
      join_row_type want;
      if (expected_join_rows.size() == 0) begin
         report_mismatch($sformatf("row %0d unexpected: probe_index %0d stored_index %0d",
                                   rows_received, rsp_tdata[nlj_pkg::RSP_PIDX_LSB +: 16],
                                   rsp_tdata[nlj_pkg::RSP_SIDX_LSB +: 6]));
      end else begin
         want = expected_join_rows.pop_front();
         compare_field("probe_index", rsp_tdata[nlj_pkg::RSP_PIDX_LSB +: 16],
                       want.probe_index);
         compare_field("stored_index", rsp_tdata[nlj_pkg::RSP_SIDX_LSB +: 6],
                       want.stored_index);
         compare_field("probe_is_null", rsp_tuser[nlj_pkg::RSP_PNULL_BIT],
                       want.probe_is_null);
         compare_field("stored_is_null", rsp_tuser[nlj_pkg::RSP_SNULL_BIT],
                       want.stored_is_null);
         compare_field("overflow", rsp_tdata[nlj_pkg::RSP_OVF_BIT], want.overflow);
         compare_field("last", rsp_tlast, want.last);
      end
      rows_received++;
   endtask

   // one request transaction, with an optional random gap in front
   task automatic send_request(input nlj_pkg::func_type func, input logic [63:0] key);
      if (!steady_flow && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      join_predict(func, key);
   endtask

   // stop sending until every row has arrived and the engine has gone idle
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (expected_join_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input nlj_pkg::reg_sel_type sel, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (sel == nlj_pkg::REG_JOIN_MODE) active_mode = nlj_pkg::mode_type'(value[1:0]);
      else active_mask = value;
      @(posedge clock);
   endtask

   task automatic set_join_config(input nlj_pkg::mode_type mode, input logic [63:0] mask);
      wait_until_drained();
      write_register(nlj_pkg::REG_JOIN_MODE, {62'd0, mode});
      write_register(nlj_pkg::REG_KEY_MASK, mask);
   endtask

   // hand-picked keys through every mode, mask extremes, flush and clear
   task automatic test_directed_cases();
      set_join_config(nlj_pkg::MODE_INNER, '1);
      send_request(nlj_pkg::FUNC_LOAD, 64'h0);
      send_request(nlj_pkg::FUNC_LOAD, '1);
      send_request(nlj_pkg::FUNC_LOAD, 64'h5555_5555_5555_5555);
      send_request(nlj_pkg::FUNC_LOAD, 64'h0);
      send_request(nlj_pkg::FUNC_PROBE, 64'h0);
      send_request(nlj_pkg::FUNC_PROBE, '1);
      send_request(nlj_pkg::FUNC_PROBE, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(nlj_pkg::FUNC_FLUSH, random_key());
      set_join_config(nlj_pkg::MODE_LEFT, '1);
      send_request(nlj_pkg::FUNC_PROBE, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(nlj_pkg::FUNC_PROBE, 64'h5555_5555_5555_5555);
      set_join_config(nlj_pkg::MODE_FULL, '1);
      send_request(nlj_pkg::FUNC_PROBE, '1);
      send_request(nlj_pkg::FUNC_PROBE, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(nlj_pkg::FUNC_FLUSH, random_key());
      send_request(nlj_pkg::FUNC_FLUSH, random_key());
      set_join_config(nlj_pkg::MODE_CROSS, '1);
      send_request(nlj_pkg::FUNC_PROBE, 64'hAAAA_AAAA_AAAA_AAAA);
      set_join_config(nlj_pkg::MODE_INNER, 64'h0);
      send_request(nlj_pkg::FUNC_PROBE, 64'hAAAA_AAAA_AAAA_AAAA);
      // marks from the earlier full-mode probe stay set
      set_join_config(nlj_pkg::MODE_FULL, 64'hFFFF_FFFF_0000_0000);
      send_request(nlj_pkg::FUNC_PROBE, 64'h5555_5555_0000_0000);
      send_request(nlj_pkg::FUNC_FLUSH, random_key());
      send_request(nlj_pkg::FUNC_CLEAR, random_key());
      send_request(nlj_pkg::FUNC_FLUSH, random_key());
      send_request(nlj_pkg::FUNC_PROBE, 64'h0);
   endtask

   // loads past a full table are dropped and set the sticky flag
   task automatic test_table_overflow();
      logic [63:0] loaded [66];
      set_join_config(nlj_pkg::MODE_CROSS, '1);
      send_request(nlj_pkg::FUNC_CLEAR, random_key());
      foreach (loaded[i]) begin
         loaded[i] = random_key();
         send_request(nlj_pkg::FUNC_LOAD, loaded[i]);
      end
      send_request(nlj_pkg::FUNC_PROBE, random_key());
      set_join_config(nlj_pkg::MODE_FULL, '1);
      send_request(nlj_pkg::FUNC_PROBE, loaded[nlj_pkg::TABLE_DEPTH-1]);
      send_request(nlj_pkg::FUNC_PROBE, loaded[nlj_pkg::TABLE_DEPTH]);
      send_request(nlj_pkg::FUNC_FLUSH, random_key());
      send_request(nlj_pkg::FUNC_CLEAR, random_key());
      send_request(nlj_pkg::FUNC_PROBE, random_key());
   endtask

   // long receiver hold-off while probes keep coming, then a full drain
   task automatic test_output_backpressure();
      set_join_config(nlj_pkg::MODE_CROSS, '1);
      send_request(nlj_pkg::FUNC_CLEAR, random_key());
      repeat (8) send_request(nlj_pkg::FUNC_LOAD, random_key());
      hold_off_request = 1'b1;
      repeat (12) send_request(nlj_pkg::FUNC_PROBE, random_key());
      wait_until_drained();
   endtask

   // random configurations, tables and request mixes
   task automatic test_random_joins();
      logic [63:0] key_pool [4];
      logic [63:0] key;
      int unsigned first_request;
      int unsigned phase;
      int unsigned fill;
      int unsigned pick;
      first_request = requests_sent;
      phase = 0;
      while (requests_sent - first_request < RANDOM_ITEMS) begin
         case ($urandom_range(5))
            0: key = '1;
            1: key = '0;
            2: key = random_key();
            3: key = 64'hF;
            4: key = 64'h1 << $urandom_range(63);
            default: key = random_key() & random_key();
         endcase
         set_join_config(nlj_pkg::mode_type'($urandom_range(3)), key);
         foreach (key_pool[i]) key_pool[i] = random_key();
         // one phase runs with no idling on either side
         steady_flow = (phase == 3);
         if ($urandom_range(3) != 0) send_request(nlj_pkg::FUNC_CLEAR, random_key());
         fill = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(10);
         repeat (fill) begin
            key = key_pool[$urandom_range(3)];
            if ($urandom_range(1)) key = key ^ (random_key() & ~active_mask);
            send_request(nlj_pkg::FUNC_LOAD, key);
         end
         repeat ($urandom_range(6, 20)) begin
            key = key_pool[$urandom_range(3)];
            if ($urandom_range(1)) key = key ^ (random_key() & ~active_mask);
            pick = $urandom_range(99);
            if (pick < 55) send_request(nlj_pkg::FUNC_PROBE, key);
            else if (pick < 70) send_request(nlj_pkg::FUNC_FLUSH, random_key());
            else if (pick < 85) send_request(nlj_pkg::FUNC_LOAD, key);
            else if (pick < 88) send_request(nlj_pkg::FUNC_CLEAR, random_key());
            else send_request(nlj_pkg::func_type'($urandom_range(3)), random_key());
         end
         steady_flow = 1'b0;
         phase++;
      end
   endtask

   // result receiver: checks each row and drives rsp_tready
   initial begin : rsp_receiver
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_join_row();
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_left    = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady_flow || ($urandom_range(99) >= 19);
         end
      end
   end

   // watchdog on cycles with no transaction on either stream
   initial begin : stall_watchdog
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL nested_loop_join_engine");
      $finish;
   end

   initial begin : test_sequence
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_table_overflow();
      test_output_backpressure();
      test_random_joins();
      wait_until_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (expected_join_rows.size() != 0)
         report_mismatch($sformatf("%0d expected rows never arrived", expected_join_rows.size()));
      if (error_count == 0) begin
         $display("PASS nested_loop_join_engine");
      end else begin
         $display("FAIL nested_loop_join_engine");
      end
      $finish;
   end

endmodule
